// ===== rtl/imcol_pkg.sv =====
// Package for the im2col patch gather block: request and response types,
// configuration and command codes, sequencer states and sizing constants.
// Used by imcol_div and the core; depends on nothing else.
package imcol_pkg;

    // Sizing of the block.
    localparam int STORE_WORDS   = 16384;
    localparam int MAX_DIM       = 32;
    localparam int MAX_KERNEL    = 7;
    localparam int CHANNEL_LIMIT = 16;
    localparam int STRIDE_LIMIT  = 4;

    localparam int STORE_AW = $clog2(STORE_WORDS);
    // Width of a linear pixel address before it is checked against the store.
    localparam int LIN_W = 18;
    localparam logic [LIN_W-1:0] STORE_LIMIT = LIN_W'(STORE_WORDS);

    // Field widths.
    localparam int PIX_W     = 32;
    localparam int ADDR_W    = 14;
    localparam int MROW_W    = 10;
    localparam int MCOL_W    = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 6;

    // Iterative divider: dividend bits, divisor bits, quotient bits per cycle.
    localparam int DIV_N     = 10;
    localparam int DIV_D     = 6;
    localparam int DIV_RADIX = 2;
    localparam int DIV_STEPS = DIV_N / DIV_RADIX;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_STEP   = 3'd4;

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] pixel_addr;
        logic [PIX_W-1:0]  pixel_value;
        logic [MROW_W-1:0] mat_row;
        logic [MCOL_W-1:0] mat_col;
    } t_request;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             padded;
        logic             fault;
    } t_response;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIZE,
        ST_LIMIT,
        ST_CHECK,
        ST_SPLIT,
        ST_KERNEL,
        ST_POS,
        ST_ADDR,
        ST_LOOK,
        ST_FETCH,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/imcol_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Stands alone; depends on no package.
module imcol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/imcol_div.sv =====
// Iterative restoring divider, two quotient bits per cycle.
// Uses imcol_pkg for its operand widths and step count.
module imcol_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [imcol_pkg::DIV_N-1:0]   i_dividend,
    input  logic [imcol_pkg::DIV_D-1:0]   i_divisor,
    output logic                          o_done,
    output logic [imcol_pkg::DIV_N-1:0]   o_quotient,
    output logic [imcol_pkg::DIV_D-1:0]   o_remainder
);

    logic                               r_busy;
    logic                               r_done;
    logic [imcol_pkg::DIV_CNT_W-1:0]    r_count;
    logic [imcol_pkg::DIV_N-1:0]        r_quo;
    logic [imcol_pkg::DIV_D-1:0]        r_rem;
    logic [imcol_pkg::DIV_D-1:0]        r_div;
    logic [imcol_pkg::DIV_N-1:0]        n_quo;
    logic [imcol_pkg::DIV_D-1:0]        n_rem;
    logic [imcol_pkg::DIV_D:0]          trial;
    logic                               qbit;

    // The quotient register starts out holding the dividend; each step shifts
    // one dividend bit into the partial remainder and one quotient bit in.
    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        trial = '0;
        qbit  = 1'b0;
        for (int i = 0; i < imcol_pkg::DIV_RADIX; i++) begin
            trial = {n_rem, n_quo[imcol_pkg::DIV_N-1]};
            if (trial >= {1'b0, r_div}) begin
                n_rem = imcol_pkg::DIV_D'(trial - {1'b0, r_div});
                qbit  = 1'b1;
            end else begin
                n_rem = trial[imcol_pkg::DIV_D-1:0];
                qbit  = 1'b0;
            end
            n_quo = {n_quo[imcol_pkg::DIV_N-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_count <= imcol_pkg::DIV_CNT_W'(imcol_pkg::DIV_STEPS);
        end else if (r_busy) begin
            r_count <= r_count - imcol_pkg::DIV_CNT_W'(1);
            if (r_count == imcol_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== rtl/im2col_patch_gather_core.sv =====
// im2col patch gather: a planar pixel store with im2col element lookup.
// Depends on imcol_pkg, imcol_ram and imcol_div.
//
// The block keeps a planar image in a 16384-word pixel store and answers one
// request at a time. A write request stores a 32-bit word at a linear address
// x + (y + channel * height) * width and returns an all-zero response, or a
// fault response when the address lies beyond the configured image or the
// store. A read request names an element of the im2col column matrix by row
// and column; the block splits the row into channel, kernel row and kernel
// column, splits the column into output y and x, places the kernel tap with
// its top-left offset of minus half the kernel size (plus one for even
// sizes), and returns the stored pixel, or zero with padded set when the tap
// falls outside the image. Indexes beyond the configured matrix raise fault.
// Out-of-range register values are used clamped into their legal ranges.
// A write, or a read whose indexes fault, passes through the size, limit,
// check and done states between acceptances; a read also makes two passes
// through the two-bit-per-cycle divider (row by kernel area, then the
// remainder by kernel side, with the column split by output width running
// alongside the first pass), followed by the address multiply and the
// registered read of the store, which a padded tap skips.
// A finished response sits in an output register, so the next request is
// accepted while the previous response still waits to be taken. The store
// has no reset; a word must be written before it is read. Configuration
// writes are always accepted and should only be issued while no request is
// outstanding.
module im2col_patch_gather_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Request channel.
    input  logic                                 i_req_valid,
    output logic                                 o_req_ready,
    input  imcol_pkg::t_request                  i_req,
    // Response channel.
    output logic                                 o_rsp_valid,
    input  logic                                 i_rsp_ready,
    output imcol_pkg::t_response                 o_rsp,
    // Configuration write channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [imcol_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [imcol_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration registers.
    logic [5:0] r_img_width;
    logic [5:0] r_img_height;
    logic [4:0] r_channel_count;
    logic [2:0] r_kernel_size;
    logic [2:0] r_stride_step;

    // Clamped configuration.
    logic [5:0] w_c;
    logic [5:0] h_c;
    logic [4:0] nc_c;
    logic [2:0] k_c;
    logic [2:0] s_c;

    imcol_pkg::t_state    r_state;
    imcol_pkg::t_state    n_state;
    imcol_pkg::t_request  r_req;
    imcol_pkg::t_response r_res;
    imcol_pkg::t_response res_next;
    imcol_pkg::t_response r_rsp;
    logic                 r_rsp_valid;
    logic                 res_we;
    logic                 rsp_load;

    // Derived sizes, computed in the size and limit states after each request arrives.
    logic [11:0] r_hw;
    logic [5:0]  r_kk;
    logic [5:0]  r_outw;
    logic [5:0]  r_outh;
    logic [16:0] r_lim_pix;
    logic [10:0] r_lim_row;
    logic [11:0] r_lim_col;

    // Decomposed indexes and tap position.
    logic [4:0]  r_ch;
    logic [5:0]  r_oy;
    logic [5:0]  r_ox;
    logic [2:0]  r_ky;
    logic [2:0]  r_kx;
    logic [5:0]  r_y;
    logic [5:0]  r_x;
    logic        r_pad;
    logic [10:0] r_chh;
    logic [imcol_pkg::LIN_W-1:0] r_lin;

    logic        wr_fault;
    logic        rd_fault;
    logic [1:0]  off_mag;
    logic [9:0]  y_pos;
    logic [9:0]  x_pos;
    logic        pad_now;
    logic [imcol_pkg::LIN_W-1:0] wr_wide;
    logic [imcol_pkg::LIN_W-1:0] lin_next;

    // Divider connections.
    logic                          row_start;
    logic                          col_start;
    logic [imcol_pkg::DIV_N-1:0]   row_dividend;
    logic [imcol_pkg::DIV_D-1:0]   row_divisor;
    logic                          row_done;
    logic                          col_done;
    logic [imcol_pkg::DIV_N-1:0]   row_quo;
    logic [imcol_pkg::DIV_D-1:0]   row_rem;
    logic [imcol_pkg::DIV_N-1:0]   col_quo;
    logic [imcol_pkg::DIV_D-1:0]   col_rem;

    // Store connections.
    logic                           ram_we;
    logic                           ram_re;
    logic [imcol_pkg::PIX_W-1:0]    ram_rdata;

    // Number of output positions along one image side: (dim - 1) / step + 1.
    // Division by three is a multiply by 171/512, exact for values below 64.
    function automatic logic [5:0] out_span(input logic [5:0] dim, input logic [2:0] step);
        logic [5:0]  last;
        logic [13:0] prod;
        logic [5:0]  q;
        begin
            last = dim - 6'd1;
            prod = 14'(last) * 14'd171;
            case (step)
                3'd2:    q = last >> 1;
                3'd3:    q = {1'b0, prod[13:9]};
                3'd4:    q = last >> 2;
                default: q = last;
            endcase
            return q + 6'd1;
        end
    endfunction

    // Each register is used clamped into its legal range; zero counts as one.
    always_comb begin
        w_c = r_img_width;
        if (r_img_width == 6'd0) begin
            w_c = 6'd1;
        end else if (32'(r_img_width) > imcol_pkg::MAX_DIM) begin
            w_c = 6'(imcol_pkg::MAX_DIM);
        end
        h_c = r_img_height;
        if (r_img_height == 6'd0) begin
            h_c = 6'd1;
        end else if (32'(r_img_height) > imcol_pkg::MAX_DIM) begin
            h_c = 6'(imcol_pkg::MAX_DIM);
        end
        nc_c = r_channel_count;
        if (r_channel_count == 5'd0) begin
            nc_c = 5'd1;
        end else if (32'(r_channel_count) > imcol_pkg::CHANNEL_LIMIT) begin
            nc_c = 5'(imcol_pkg::CHANNEL_LIMIT);
        end
        k_c = r_kernel_size;
        if (r_kernel_size == 3'd0) begin
            k_c = 3'd1;
        end else if (32'(r_kernel_size) > imcol_pkg::MAX_KERNEL) begin
            k_c = 3'(imcol_pkg::MAX_KERNEL);
        end
        s_c = r_stride_step;
        if (r_stride_step == 3'd0) begin
            s_c = 3'd1;
        end else if (32'(r_stride_step) > imcol_pkg::STRIDE_LIMIT) begin
            s_c = 3'(imcol_pkg::STRIDE_LIMIT);
        end
    end

    // Configuration writes; indexes past the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width     <= 6'd32;
            r_img_height    <= 6'd32;
            r_channel_count <= 5'd1;
            r_kernel_size   <= 3'd3;
            r_stride_step   <= 3'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                imcol_pkg::CFG_IMG_WIDTH:     r_img_width     <= i_cfg_data[5:0];
                imcol_pkg::CFG_IMG_HEIGHT:    r_img_height    <= i_cfg_data[5:0];
                imcol_pkg::CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[4:0];
                imcol_pkg::CFG_KERNEL_SIZE:   r_kernel_size   <= i_cfg_data[2:0];
                imcol_pkg::CFG_STRIDE_STEP:   r_stride_step   <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Range checks against the limits registered in the previous cycle.
    assign wr_wide  = imcol_pkg::LIN_W'(r_req.pixel_addr);
    assign wr_fault = ({3'b0, r_req.pixel_addr} >= r_lim_pix) ||
                      (wr_wide >= imcol_pkg::STORE_LIMIT);
    assign rd_fault = ({1'b0, r_req.mat_row} >= r_lim_row) ||
                      ({2'b0, r_req.mat_col} >= r_lim_col);

    // Tap position. The kernel offset magnitude is size/2, less one for even
    // sizes. A negative position wraps above 511 and so also fails the
    // upper-bound compare.
    assign off_mag = k_c[2:1] - {1'b0, ~k_c[0]};
    assign y_pos   = 10'(r_oy) * 10'(s_c) + 10'(r_ky) - 10'(off_mag);
    assign x_pos   = 10'(r_ox) * 10'(s_c) + 10'(r_kx) - 10'(off_mag);
    assign pad_now = (y_pos >= 10'(h_c)) || (x_pos >= 10'(w_c));

    assign lin_next = imcol_pkg::LIN_W'(r_x) +
                      (imcol_pkg::LIN_W'(r_y) + imcol_pkg::LIN_W'(r_chh)) *
                      imcol_pkg::LIN_W'(w_c);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            imcol_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = imcol_pkg::ST_SIZE;
                end
            end
            imcol_pkg::ST_SIZE:  n_state = imcol_pkg::ST_LIMIT;
            imcol_pkg::ST_LIMIT: n_state = imcol_pkg::ST_CHECK;
            imcol_pkg::ST_CHECK: begin
                if (r_req.command == imcol_pkg::CMD_WRITE || rd_fault) begin
                    n_state = imcol_pkg::ST_DONE;
                end else begin
                    n_state = imcol_pkg::ST_SPLIT;
                end
            end
            imcol_pkg::ST_SPLIT: begin
                if (row_done && col_done) begin
                    n_state = imcol_pkg::ST_KERNEL;
                end
            end
            imcol_pkg::ST_KERNEL: begin
                if (row_done) begin
                    n_state = imcol_pkg::ST_POS;
                end
            end
            imcol_pkg::ST_POS: n_state = imcol_pkg::ST_ADDR;
            imcol_pkg::ST_ADDR: begin
                if (r_pad) begin
                    n_state = imcol_pkg::ST_DONE;
                end else begin
                    n_state = imcol_pkg::ST_LOOK;
                end
            end
            imcol_pkg::ST_LOOK: begin
                if (r_lin >= imcol_pkg::STORE_LIMIT) begin
                    n_state = imcol_pkg::ST_DONE;
                end else begin
                    n_state = imcol_pkg::ST_FETCH;
                end
            end
            imcol_pkg::ST_FETCH: n_state = imcol_pkg::ST_DONE;
            imcol_pkg::ST_DONE: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_state = imcol_pkg::ST_IDLE;
                end
            end
            default: n_state = imcol_pkg::ST_IDLE;
        endcase
    end

    // Output logic of the sequencer.
    always_comb begin
        o_req_ready  = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        row_start    = 1'b0;
        col_start    = 1'b0;
        row_dividend = r_req.mat_row;
        row_divisor  = r_kk;
        res_we       = 1'b0;
        res_next     = '0;
        rsp_load     = 1'b0;
        case (r_state)
            imcol_pkg::ST_IDLE: o_req_ready = 1'b1;
            imcol_pkg::ST_CHECK: begin
                res_we = 1'b1;
                if (r_req.command == imcol_pkg::CMD_WRITE) begin
                    res_next.fault = wr_fault;
                    ram_we         = !wr_fault;
                end else if (rd_fault) begin
                    res_next.fault = 1'b1;
                end else begin
                    row_start = 1'b1;
                    col_start = 1'b1;
                end
            end
            imcol_pkg::ST_SPLIT: begin
                // Second pass: the kernel-area remainder split by kernel side.
                row_dividend = imcol_pkg::DIV_N'(row_rem);
                row_divisor  = imcol_pkg::DIV_D'(k_c);
                row_start    = row_done && col_done;
            end
            imcol_pkg::ST_ADDR: begin
                if (r_pad) begin
                    res_we          = 1'b1;
                    res_next.padded = 1'b1;
                end
            end
            imcol_pkg::ST_LOOK: begin
                if (r_lin >= imcol_pkg::STORE_LIMIT) begin
                    res_we         = 1'b1;
                    res_next.fault = 1'b1;
                end else begin
                    ram_re = 1'b1;
                end
            end
            imcol_pkg::ST_FETCH: begin
                res_we         = 1'b1;
                res_next.value = ram_rdata;
            end
            imcol_pkg::ST_DONE: rsp_load = !r_rsp_valid || i_rsp_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imcol_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers; they carry payload only and need no reset.
    always_ff @(posedge i_clk) begin
        if (r_state == imcol_pkg::ST_IDLE && i_req_valid) begin
            r_req <= i_req;
        end
        if (r_state == imcol_pkg::ST_SIZE) begin
            r_hw   <= 12'(w_c) * 12'(h_c);
            r_kk   <= 6'(k_c) * 6'(k_c);
            r_outw <= out_span(w_c, s_c);
            r_outh <= out_span(h_c, s_c);
        end
        if (r_state == imcol_pkg::ST_LIMIT) begin
            r_lim_pix <= 17'(nc_c) * 17'(r_hw);
            r_lim_row <= 11'(nc_c) * 11'(r_kk);
            r_lim_col <= 12'(r_outw) * 12'(r_outh);
        end
        if (r_state == imcol_pkg::ST_SPLIT && row_done && col_done) begin
            r_ch <= row_quo[4:0];
            r_oy <= col_quo[5:0];
            r_ox <= col_rem;
        end
        if (r_state == imcol_pkg::ST_KERNEL && row_done) begin
            r_ky <= row_quo[2:0];
            r_kx <= row_rem[2:0];
        end
        if (r_state == imcol_pkg::ST_POS) begin
            r_y   <= y_pos[5:0];
            r_x   <= x_pos[5:0];
            r_pad <= pad_now;
            r_chh <= 11'(r_ch) * 11'(h_c);
        end
        if (r_state == imcol_pkg::ST_ADDR) begin
            r_lin <= lin_next;
        end
        if (res_we) begin
            r_res <= res_next;
        end
        if (rsp_load) begin
            r_rsp <= r_res;
        end
    end

    // Output register: it frees the sequencer as soon as a response is parked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (rsp_load) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Row divider: matrix row by kernel area, then the remainder by kernel side.
    imcol_div u_row_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (row_start),
        .i_dividend  (row_dividend),
        .i_divisor   (row_divisor),
        .o_done      (row_done),
        .o_quotient  (row_quo),
        .o_remainder (row_rem)
    );

    // Column divider: matrix column by output width.
    imcol_div u_col_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (col_start),
        .i_dividend  (r_req.mat_col),
        .i_divisor   (r_outw),
        .o_done      (col_done),
        .o_quotient  (col_quo),
        .o_remainder (col_rem)
    );

    imcol_ram #(
        .WIDTH (imcol_pkg::PIX_W),
        .DEPTH (imcol_pkg::STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_wide[imcol_pkg::STORE_AW-1:0]),
        .i_wdata (r_req.pixel_value),
        .i_re    (ram_re),
        .i_raddr (r_lin[imcol_pkg::STORE_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // A response never carries both pad and fault.
    a_pad_fault_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_rsp.padded && o_rsp.fault))
        else $error("response flags both padded and fault");

    // Padded and faulted responses return a zero word.
    a_flagged_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_rsp.padded || o_rsp.fault)) |-> (o_rsp.value == '0))
        else $error("flagged response carries a nonzero value");

    // The store is written only for a write request during the range check.
    a_write_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == imcol_pkg::ST_CHECK &&
                    r_req.command == imcol_pkg::CMD_WRITE && !wr_fault))
        else $error("store written outside a legal write request");

    // A store read is issued only for an address inside the store.
    a_read_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (r_lin < imcol_pkg::STORE_LIMIT))
        else $error("store read beyond its depth");

    // Both dividers start together and so finish together.
    a_dividers_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == imcol_pkg::ST_SPLIT) |-> (row_done == col_done))
        else $error("row and column dividers out of step");

endmodule
